// File: rtl/rmd160_pkg.sv
// ----------------------------------------------------------------------------
// rmd160_pkg
// Shared types, constants, step tables and helper functions for the
// RIPEMD-160 block compression core.
// ----------------------------------------------------------------------------
`default_nettype none

package rmd160_pkg;

	localparam int unsigned WORDS_PER_BLOCK = 16;
	localparam int unsigned CHAIN_WORDS     = 5;
	localparam int unsigned NUM_STEPS       = 80;

	typedef logic [31:0] word_t;
	typedef logic [3:0]  word_idx_t;
	typedef logic [2:0]  chain_idx_t;
	typedef logic [6:0]  step_t;
	typedef logic [2:0]  rnd_t;
	typedef logic [3:0]  rot_t;

	localparam word_idx_t LAST_WORD_IDX = word_idx_t'(WORDS_PER_BLOCK - 1);
	localparam word_idx_t CHAIN_LIMIT   = word_idx_t'(CHAIN_WORDS);
	localparam step_t     LAST_STEP     = step_t'(NUM_STEPS);
	localparam chain_idx_t LAST_POS     = chain_idx_t'(CHAIN_WORDS - 1);
	localparam logic [2:0] OUT_FULL     = 3'(CHAIN_WORDS);
	localparam rot_t      ROT_C         = 4'd10;

	// boolean function selects
	localparam rnd_t FN_XOR  = 3'd0;
	localparam rnd_t FN_MUX  = 3'd1;
	localparam rnd_t FN_ORN  = 3'd2;
	localparam rnd_t FN_MUXZ = 3'd3;
	localparam rnd_t FN_XORN = 3'd4;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_RUN,
		ST_MERGE
	} state_t;

	typedef struct packed {
		word_t message_word;
		word_t chain_word;
	} in_item_t;

	typedef struct packed {
		word_t      digest_word;
		chain_idx_t word_position;
		logic       last_word;
	} out_item_t;

	typedef struct packed {
		logic      wr_en;
		word_idx_t wr_idx;
		logic      rd_en;
		step_t     rd_step;
		logic      load;
		logic      ex_en;
		logic      merge;
	} dp_cmd_t;

	typedef struct packed {
		logic out_idle;
	} dp_status_t;

	localparam word_idx_t L_WORD [0:79] = '{
		4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
		4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
		4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
		4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
		4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
		4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
		4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
		4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
		4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13
	};

	localparam word_idx_t R_WORD [0:79] = '{
		4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
		4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
		4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
		4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
		4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
		4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
		4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
		4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
		4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
		4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11
	};

	localparam rot_t L_ROT [0:79] = '{
		4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
		4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
		4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
		4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
		4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
		4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
		4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
		4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12,
		4'd9, 4'd15, 4'd5, 4'd11, 4'd6, 4'd8, 4'd13, 4'd12,
		4'd5, 4'd12, 4'd13, 4'd14, 4'd11, 4'd8, 4'd5, 4'd6
	};

	localparam rot_t R_ROT [0:79] = '{
		4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
		4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
		4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
		4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
		4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
		4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
		4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
		4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8,
		4'd8, 4'd5, 4'd12, 4'd9, 4'd12, 4'd5, 4'd14, 4'd6,
		4'd8, 4'd13, 4'd6, 4'd5, 4'd15, 4'd13, 4'd11, 4'd11
	};

	localparam word_t L_K [0:4] = '{
		32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E
	};

	localparam word_t R_K [0:4] = '{
		32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000
	};

	// sixteen steps to a round
	function automatic rnd_t round_of(input step_t step);
		return step[6:4];
	endfunction

	function automatic word_t rotl32(input word_t x, input rot_t n);
		logic [4:0] back;
		back = 5'd0 - {1'b0, n};
		return (x << n) | (x >> back);
	endfunction

	function automatic word_t bool_fn(input rnd_t sel, input word_t x, input word_t y,
			input word_t z);
		word_t f;
		case (sel)
			FN_XOR:  f = x ^ y ^ z;
			FN_MUX:  f = (x & y) | (~x & z);
			FN_ORN:  f = (x | ~y) ^ z;
			FN_MUXZ: f = (x & z) | (y & ~z);
			default: f = x ^ (y | ~z);
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

// File: rtl/rmd160_ctrl.sv
// ----------------------------------------------------------------------------
// rmd160_ctrl
// Sequencer: collects the sixteen words of a block, walks the 80 steps and
// starts the merge once the output stage has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module rmd160_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   word_valid,
	output logic                        word_ready,
	input  wire rmd160_pkg::dp_status_t status,
	output rmd160_pkg::dp_cmd_t         cmd
);

	rmd160_pkg::state_t    state_q, state_nxt;
	rmd160_pkg::word_idx_t cnt_q;
	rmd160_pkg::step_t     step_q;
	logic                  accept;

	assign accept = word_valid && word_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmd160_pkg::ST_FILL;
			cnt_q   <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (state_q == rmd160_pkg::ST_RUN) begin
				step_q <= step_q + 7'd1;
			end else begin
				step_q <= '0;
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rmd160_pkg::ST_FILL: begin
				if (accept && cnt_q == rmd160_pkg::LAST_WORD_IDX) begin
					state_nxt = rmd160_pkg::ST_RUN;
				end
			end
			rmd160_pkg::ST_RUN: begin
				if (step_q == rmd160_pkg::LAST_STEP) begin
					state_nxt = rmd160_pkg::ST_MERGE;
				end
			end
			rmd160_pkg::ST_MERGE: begin
				if (status.out_idle) begin
					state_nxt = rmd160_pkg::ST_FILL;
				end
			end
			default: state_nxt = rmd160_pkg::ST_FILL;
		endcase
	end

	// outputs
	always_comb begin
		word_ready  = 1'b0;
		cmd         = '0;
		cmd.wr_idx  = cnt_q;
		cmd.rd_step = step_q;
		case (state_q)
			rmd160_pkg::ST_FILL: begin
				word_ready = 1'b1;
				cmd.wr_en  = word_valid;
			end
			rmd160_pkg::ST_RUN: begin
				cmd.rd_en = (step_q != rmd160_pkg::LAST_STEP);
				cmd.load  = (step_q == '0);
				cmd.ex_en = (step_q != '0);
			end
			rmd160_pkg::ST_MERGE: begin
				cmd.merge = status.out_idle;
			end
			default: begin
				word_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/rmd160_dp.sv
// ----------------------------------------------------------------------------
// rmd160_dp
// Datapath: message memory, chaining buffer, operand fetch, one left and one
// right step per cycle, final merge and the five-word output shifter.
// ----------------------------------------------------------------------------
`default_nettype none

module rmd160_dp (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire rmd160_pkg::dp_cmd_t    cmd,
	output rmd160_pkg::dp_status_t      status,
	input  wire rmd160_pkg::in_item_t   word,
	output logic                        digest_valid,
	input  wire logic                   digest_ready,
	output rmd160_pkg::out_item_t       digest
);

	rmd160_pkg::word_t      msg_mem [16];
	rmd160_pkg::word_t      chain_q [5];
	rmd160_pkg::word_t      l_q [5];
	rmd160_pkg::word_t      r_q [5];
	rmd160_pkg::word_t      out_word_q [5];
	rmd160_pkg::word_t      wk_l_s1, wk_r_s1;
	rmd160_pkg::rot_t       rot_l_s1, rot_r_s1;
	rmd160_pkg::rnd_t       rnd_s1;
	rmd160_pkg::rnd_t       rd_rnd;
	rmd160_pkg::word_t      t_l, t_r;
	logic [2:0]             out_cnt_q;
	rmd160_pkg::chain_idx_t out_pos_q;
	logic                   out_take;

	assign rd_rnd = rmd160_pkg::round_of(cmd.rd_step);

	// message words and incoming chaining words
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			msg_mem[cmd.wr_idx] <= word.message_word;
			if (cmd.wr_idx < rmd160_pkg::CHAIN_LIMIT) begin
				chain_q[cmd.wr_idx[2:0]] <= word.chain_word;
			end
		end
	end

	// operand fetch, one step ahead of execution
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			wk_l_s1  <= msg_mem[rmd160_pkg::L_WORD[cmd.rd_step]] + rmd160_pkg::L_K[rd_rnd];
			wk_r_s1  <= msg_mem[rmd160_pkg::R_WORD[cmd.rd_step]] + rmd160_pkg::R_K[rd_rnd];
			rot_l_s1 <= rmd160_pkg::L_ROT[cmd.rd_step];
			rot_r_s1 <= rmd160_pkg::R_ROT[cmd.rd_step];
			rnd_s1   <= rd_rnd;
		end
	end

	assign t_l = rmd160_pkg::rotl32(l_q[0]
		+ rmd160_pkg::bool_fn(rnd_s1, l_q[1], l_q[2], l_q[3]) + wk_l_s1, rot_l_s1) + l_q[4];
	assign t_r = rmd160_pkg::rotl32(r_q[0]
		+ rmd160_pkg::bool_fn(rmd160_pkg::FN_XORN - rnd_s1, r_q[1], r_q[2], r_q[3])
		+ wk_r_s1, rot_r_s1) + r_q[4];

	// both chains
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 5; i++) begin
				l_q[i] <= chain_q[i];
				r_q[i] <= chain_q[i];
			end
		end else if (cmd.ex_en) begin
			l_q[0] <= l_q[4];
			l_q[4] <= l_q[3];
			l_q[3] <= rmd160_pkg::rotl32(l_q[2], rmd160_pkg::ROT_C);
			l_q[2] <= l_q[1];
			l_q[1] <= t_l;
			r_q[0] <= r_q[4];
			r_q[4] <= r_q[3];
			r_q[3] <= rmd160_pkg::rotl32(r_q[2], rmd160_pkg::ROT_C);
			r_q[2] <= r_q[1];
			r_q[1] <= t_r;
		end
	end

	assign out_take = digest_valid && digest_ready;

	// merge into the output shifter, then shift one word per beat
	always_ff @(posedge clk) begin
		if (cmd.merge) begin
			out_word_q[0] <= chain_q[1] + l_q[2] + r_q[3];
			out_word_q[1] <= chain_q[2] + l_q[3] + r_q[4];
			out_word_q[2] <= chain_q[3] + l_q[4] + r_q[0];
			out_word_q[3] <= chain_q[4] + l_q[0] + r_q[1];
			out_word_q[4] <= chain_q[0] + l_q[1] + r_q[2];
		end else if (out_take) begin
			for (int i = 0; i < 4; i++) begin
				out_word_q[i] <= out_word_q[i + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
			out_pos_q <= '0;
		end else if (cmd.merge) begin
			out_cnt_q <= rmd160_pkg::OUT_FULL;
			out_pos_q <= '0;
		end else if (out_take) begin
			out_cnt_q <= out_cnt_q - 3'd1;
			out_pos_q <= out_pos_q + 3'd1;
		end
	end

	assign digest_valid         = (out_cnt_q != '0);
	assign digest.digest_word   = out_word_q[0];
	assign digest.word_position = out_pos_q;
	assign digest.last_word     = (out_pos_q == rmd160_pkg::LAST_POS);
	assign status.out_idle      = (out_cnt_q == '0);

endmodule

`default_nettype wire

// File: rtl/ripemd160_block_compress.sv
// ----------------------------------------------------------------------------
// ripemd160_block_compress
// One RIPEMD-160 compression of a 512-bit block, fed one message word per
// beat, returning the five updated chaining words.
// ----------------------------------------------------------------------------
//
//   channel  | signals                          | carries
//   ---------+----------------------------------+-------------------------------
//   word     | word_valid, word_ready, word     | message word, chaining word
//   digest   | digest_valid, digest_ready,      | new chaining word, position,
//            | digest                           | last-word flag
//
// - sixteen word beats per block, one per cycle while collecting
// - after the sixteenth beat: an operand fetch, the 80 steps (one left and
//   one right step each) and a merge; no further word beat is taken
//   until that merge
// - five digest beats follow, one per cycle when digest_ready is high
// - the next block is collected while digests drain; its merge waits for
//   the output shifter to empty, so a stalled digest side holds the block
//   back only then
// - reset clears the word count, the sequencer and the output count; the
//   message and chaining stores are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module ripemd160_block_compress (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  word_valid,
	output logic                       word_ready,
	input  wire rmd160_pkg::in_item_t  word,
	output logic                       digest_valid,
	input  wire logic                  digest_ready,
	output rmd160_pkg::out_item_t      digest
);

	// command and status between sequencer and datapath
	rmd160_pkg::dp_cmd_t    cmd;
	rmd160_pkg::dp_status_t status;

	// sequencer: word count, step count, block state
	rmd160_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.status     (status),
		.cmd        (cmd)
	);

	// datapath: stores, step unit, merge and output shifter
	rmd160_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.word         (word),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest       (digest)
	);

endmodule

`default_nettype wire

// File: rtl/rmd160_chk.sv
// ----------------------------------------------------------------------------
// rmd160_chk
// Port-level checks on the digest stream of the compression core.
// ----------------------------------------------------------------------------
`default_nettype none

module rmd160_chk (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  digest_valid,
	input wire logic                  digest_ready,
	input wire rmd160_pkg::out_item_t digest
);

	logic digest_beat;

	assign digest_beat = digest_valid && digest_ready;

	// a stalled digest holds
	a_digest_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_ready |=> digest_valid && $stable(digest))
		else $error("digest changed while stalled");

	// positions run in order with no gap
	a_pos_next: assert property (@(posedge clk) disable iff (!arst_n)
		digest_beat && !digest.last_word |=>
			digest_valid && digest.word_position == $past(digest.word_position) + 3'd1)
		else $error("digest position out of order");

	// last flag only on the fifth word
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (digest.last_word == (digest.word_position == 3'd4)))
		else $error("last flag and position disagree");

	// a block's digest ends with its last word
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		digest_beat && digest.last_word |=> !digest_valid)
		else $error("digest continued after last word");

	// each block's digest starts at position zero
	a_pos_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(digest_valid) |-> digest.word_position == 3'd0)
		else $error("digest did not start at position zero");

endmodule

bind ripemd160_block_compress rmd160_chk u_rmd160_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.digest_valid (digest_valid),
	.digest_ready (digest_ready),
	.digest       (digest)
);

`default_nettype wire

// File: tb/sv/rmd160_digest_checker.sv
// ----------------------------------------------------------------------------
// rmd160_digest_checker
// Watches the word and digest channels of the compression core, rebuilds each
// block from the accepted word beats, computes the five new chaining words
// and compares every digest beat against them in order.
// ----------------------------------------------------------------------------

module rmd160_digest_checker
	import rmd160_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      word_valid,
	input  wire logic      word_ready,
	input  wire in_item_t  word,
	input  wire logic      digest_valid,
	input  wire logic      digest_ready,
	input  wire out_item_t digest,
	output int             mismatches,
	output int             digests_owed
);

	word_t     msg_store [0:15];
	word_t     chain_store [0:4];
	word_idx_t fill_pos;
	out_item_t chain_words_due [$];

	function automatic word_t rol32(input word_t x, input int n);
		if (n % 32 == 0)
			return x;
		return (x << (n % 32)) | (x >> (32 - n % 32));
	endfunction

	function automatic word_t mix(input rnd_t sel, input word_t x, input word_t y,
			input word_t z);
		case (sel)
			FN_XOR:  return x ^ y ^ z;
			FN_MUX:  return z ^ (x & (y ^ z));
			FN_ORN:  return (x | ~y) ^ z;
			FN_MUXZ: return y ^ (z & (x ^ y));
			default: return x ^ (y | ~z);
		endcase
	endfunction

	// both 80-step lines, then the cross-wise merge with the saved chain
	function automatic void push_new_chain();
		word_t     lv [0:4];
		word_t     rv [0:4];
		word_t     t;
		rnd_t      rnd;
		rnd_t      rsel;
		out_item_t item;
		for (int k = 0; k < 5; k++) begin
			lv[k] = chain_store[k];
			rv[k] = chain_store[k];
		end
		for (int j = 0; j < 80; j++) begin
			rnd  = rnd_t'(j / 16);
			rsel = rnd_t'(4 - j / 16);
			t = rol32(lv[0] + mix(rnd, lv[1], lv[2], lv[3]) + msg_store[L_WORD[j]] + L_K[rnd],
				int'(L_ROT[j])) + lv[4];
			lv[0] = lv[4];
			lv[4] = lv[3];
			lv[3] = rol32(lv[2], 10);
			lv[2] = lv[1];
			lv[1] = t;
			t = rol32(rv[0] + mix(rsel, rv[1], rv[2], rv[3]) + msg_store[R_WORD[j]] + R_K[rnd],
				int'(R_ROT[j])) + rv[4];
			rv[0] = rv[4];
			rv[4] = rv[3];
			rv[3] = rol32(rv[2], 10);
			rv[2] = rv[1];
			rv[1] = t;
		end
		for (int k = 0; k < 5; k++) begin
			item.digest_word   = chain_store[(k + 1) % 5] + lv[(k + 2) % 5] + rv[(k + 3) % 5];
			item.word_position = chain_idx_t'(k);
			item.last_word     = (k == 4);
			chain_words_due.push_back(item);
		end
	endfunction

	task automatic report_mismatch(input string what, input word_t got, input word_t want);
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	initial begin
		mismatches   = 0;
		digests_owed = 0;
		fill_pos     = '0;
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (word_valid && word_ready) begin
				msg_store[fill_pos] = word.message_word;
				if (fill_pos < CHAIN_LIMIT)
					chain_store[fill_pos] = word.chain_word;
				if (fill_pos == LAST_WORD_IDX) begin
					push_new_chain();
					fill_pos = '0;
				end else begin
					fill_pos = fill_pos + 1'b1;
				end
			end
			if (digest_valid && digest_ready) begin
				if (chain_words_due.size() == 0) begin
					report_mismatch("unexpected digest beat", digest.digest_word, '0);
				end else begin
					want = chain_words_due.pop_front();
					if (digest.digest_word !== want.digest_word)
						report_mismatch("digest_word", digest.digest_word, want.digest_word);
					if (digest.word_position !== want.word_position)
						report_mismatch("word_position", word_t'(digest.word_position),
							word_t'(want.word_position));
					if (digest.last_word !== want.last_word)
						report_mismatch("last_word", word_t'(digest.last_word),
							word_t'(want.last_word));
				end
			end
			digests_owed = chain_words_due.size();
		end
	end

endmodule

// File: tb/sv/ripemd160_block_compress_tb.sv
// ----------------------------------------------------------------------------
// ripemd160_block_compress_tb
// Feeds whole 16-word blocks into the compression core, first one block of
// edge-case words, then random blocks, with random stalls on both channels outside the calm stretch.
// A separate checker predicts the five chaining words of each block.
// ----------------------------------------------------------------------------

module ripemd160_block_compress_tb;
	import rmd160_pkg::*;

	localparam int RANDOM_BLOCKS = 25;
	localparam int CALM_BLOCKS   = 3;   // final blocks run with no idling
	localparam int PAUSE_BLOCK   = 12;  // sender drains the core before this one
	localparam int CYCLE_LIMIT   = 200000;
	localparam int TAIL_CYCLES   = 120; // a little over one block's compression

	// edge-case message words: extremes, single bits, alternating patterns
	localparam word_t EDGE_WORDS [0:15] = '{
		32'h00000000, 32'hFFFFFFFF, 32'h80000000, 32'h00000001,
		32'h7FFFFFFF, 32'hFFFFFFFE, 32'hAAAAAAAA, 32'h55555555,
		32'h00000080, 32'hFFFF0000, 32'h0000FFFF, 32'h01234567,
		32'h89ABCDEF, 32'hF0F0F0F0, 32'h0F0F0F0F, 32'hFFFFFFFF
	};
	localparam word_t EDGE_CHAIN [0:4] = '{
		32'hFFFFFFFF, 32'h00000000, 32'h67452301, 32'h80000000, 32'h00000001
	};

	logic      clk;
	logic      arst_n;
	logic      word_valid;
	logic      word_ready;
	in_item_t  word;
	logic      digest_valid;
	logic      digest_ready;
	out_item_t digest;

	int        mismatches;
	int        digests_owed;
	int        cycle_count;
	bit        calm;

	ripemd160_block_compress dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_ready   (word_ready),
		.word         (word),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest       (digest)
	);

	rmd160_digest_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_ready   (word_ready),
		.word         (word),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest       (digest),
		.mismatches   (mismatches),
		.digests_owed (digests_owed)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case a beat never arrives
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// mostly full-range random, with a share of all-zero, all-one, one-hot and one-cold words
	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return word_t'(1) << $urandom_range(0, 31);
			3:       return ~(word_t'(1) << $urandom_range(0, 31));
			default: return $urandom();
		endcase
	endfunction

	// one word beat; an idle burst may come first, except in the calm stretch
	task automatic send_word(input in_item_t beat);
		if (!calm && $urandom_range(0, 3) == 0) begin
			word_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		word       <= beat;
		word_valid <= 1'b1;
		@(posedge clk);
		while (!word_ready)
			@(posedge clk);
	endtask

	// holds off until the checker has seen every digest it is owed
	task automatic wait_drained();
		@(negedge clk);
		while (digests_owed != 0)
			@(negedge clk);
	endtask

	// digest side: ready in random bursts, high throughout the calm stretch
	initial begin
		digest_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (calm) begin
				digest_ready <= 1'b1;
				@(posedge clk);
			end else begin
				digest_ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
				digest_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
		end
	end

	initial begin
		in_item_t beat;
		calm       = 1'b0;
		arst_n     = 1'b0;
		word_valid = 1'b0;
		word       = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// edge-case block; chain_word on beats five to fifteen is ignored by
		// the core, so it carries all ones there to show it has no effect
		for (int i = 0; i < 16; i++) begin
			beat.message_word = EDGE_WORDS[i];
			beat.chain_word   = (i < 5) ? EDGE_CHAIN[i] : '1;
			send_word(beat);
		end

		// random blocks; framing is purely by count, so every block is whole
		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			if (b == PAUSE_BLOCK) begin
				word_valid <= 1'b0;
				wait_drained();
				// back onto the rising edge before driving again
				@(posedge clk);
			end
			if (b == RANDOM_BLOCKS - CALM_BLOCKS)
				calm = 1'b1;
			for (int i = 0; i < 16; i++) begin
				beat.message_word = pick_word();
				beat.chain_word   = (i < 5) ? pick_word() : $urandom();
				send_word(beat);
			end
		end
		word_valid <= 1'b0;

		// drain, then allow for anything late or spurious
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && digests_owed == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
